>>> hdl/bitmap_page_frame_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap page frame allocator unit
// Short forms for same-cycle and next-cycle implications.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BPFAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BPFAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication that is also checked through reset.
`define BPFAU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

>>> hdl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap page frame allocator package
// Shared address width, controller states and the command and status groups.
// ---------------------------------------------------------------------------
package bpfa_pkg;

  localparam int ADDR_W = 27;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_SCAN,
    ST_BASE,
    ST_RESULT,
    ST_MISS
  } bpfa_state_e;

  typedef struct packed {
    logic ptr_clr;
    logic ptr_inc;
    logic wr_zero;
    logic addr_load;
    logic rd_free;
    logic wr_set;
    logic rd_scan;
    logic wr_take;
    logic base_mul;
    logic out_load_hit;
    logic out_load_miss;
  } bpfa_cmd_t;

  typedef struct packed {
    logic free_oob;
    logic ptr_last;
    logic ptr_end;
    logic rd_vld;
    logic scan_hit;
  } bpfa_sts_t;

endpackage

>>> hdl/bpfa_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator channel interfaces
// Request channel (mode, address) and response channel (page, found).
// ---------------------------------------------------------------------------
interface bpfa_in_if import bpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

interface bpfa_out_if import bpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_address;
  logic              found;

  modport source (output valid, output page_address, output found, input ready);
  modport sink   (input valid, input page_address, input found, output ready);
endinterface

>>> hdl/bpfa_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences the clearing pass, the free path and the allocation scan.
// ---------------------------------------------------------------------------
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_mode_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  bpfa_sts_t sts_i,
  output bpfa_cmd_t cmd_o
);

  bpfa_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free;

  assign out_free    = !out_vld_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    out_vld_d = out_vld_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_mode_i) begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = ST_SCAN;
          end else begin
            cmd_o.addr_load = 1'b1;
            state_d         = ST_FREE_RD;
          end
        end
      end
      ST_FREE_RD: begin
        // Pages past the end of the map are dropped without a write.
        if (sts_i.free_oob) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_free = 1'b1;
          state_d       = ST_FREE_WR;
        end
      end
      ST_FREE_WR: begin
        cmd_o.wr_set = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        // Each cycle checks the word read in the previous cycle and issues the
        // next read; a hit stops the scan before another read is issued.
        if (sts_i.scan_hit) begin
          cmd_o.wr_take = 1'b1;
          state_d       = ST_BASE;
        end else if (sts_i.ptr_end && !sts_i.rd_vld) begin
          state_d = ST_MISS;
        end else if (!sts_i.ptr_end) begin
          cmd_o.rd_scan = 1'b1;
          cmd_o.ptr_inc = 1'b1;
        end
      end
      ST_BASE: begin
        cmd_o.base_mul = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.out_load_hit = 1'b1;
          out_vld_d          = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          cmd_o.out_load_miss = 1'b1;
          out_vld_d           = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bpfa_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator datapath
// Bitmap memory, page index split, scan pointer and base multiply.
// ---------------------------------------------------------------------------
module bpfa_datapath import bpfa_pkg::*; #(
  parameter int MAP_WORDS     = 1024,
  parameter int BITS_PER_WORD = 32,
  parameter int PAGE_BYTES    = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpfa_cmd_t         cmd_i,
  input  logic [ADDR_W-1:0] in_address_i,
  output bpfa_sts_t         sts_o,
  output logic [ADDR_W-1:0] page_address_o,
  output logic              found_o
);

  localparam int IDX_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W   = $clog2(MAP_WORDS + 1);
  localparam int BIT_W   = $clog2(BITS_PER_WORD);
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = ADDR_W - PAGE_SH;
  localparam int P1_W    = IDX_W + $clog2(BITS_PER_WORD + 1);
  localparam int P2_W    = P1_W + $clog2(PAGE_BYTES + 1);
  localparam int MUL_W   = (P2_W > ADDR_W) ? P2_W : ADDR_W;

  typedef logic [BITS_PER_WORD-1:0] word_t;

  // Scan and clear pointer.
  logic [CNT_W-1:0] ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_clr) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + CNT_W'(1);
    end
  end

  // Page size and word width must be powers of two (not checked here), so the page
  // number, the word index and the bit index are plain fields of the byte address.
  logic [ADDR_W-1:0] addr_q;
  logic [PAGE_W-1:0] page_num;
  logic [PAGE_W-1:0] word_num;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_q <= in_address_i;
    end
  end

  assign page_num = addr_q[ADDR_W-1:PAGE_SH];
  assign word_num = page_num >> BIT_W;

  logic [IDX_W-1:0] word_idx;
  logic [BIT_W-1:0] bit_idx;

  assign word_idx = IDX_W'(word_num);
  assign bit_idx  = page_num[BIT_W-1:0];

  // Bitmap memory with registered read data.
  word_t            mem [MAP_WORDS];
  word_t            rdata_q;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  word_t            wr_data;
  word_t            low_bit;
  logic [BIT_W-1:0] low_idx;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q;

  // Two's complement trick isolates the lowest set bit.
  assign low_bit = rdata_q & (~rdata_q + word_t'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | BIT_W'(i);
      end
    end
  end

  assign mem_re  = cmd_i.rd_scan || cmd_i.rd_free;
  assign rd_addr = cmd_i.rd_scan ? ptr_q[IDX_W-1:0] : word_idx;
  assign mem_we  = cmd_i.wr_zero || cmd_i.wr_set || cmd_i.wr_take;

  always_comb begin
    wr_addr = ptr_q[IDX_W-1:0];
    wr_data = '0;
    if (cmd_i.wr_set) begin
      wr_addr = word_idx;
      wr_data = rdata_q | (word_t'(1) << bit_idx);
    end else if (cmd_i.wr_take) begin
      wr_addr = rd_idx_q;
      wr_data = rdata_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_scan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_scan) begin
      rd_idx_q <= ptr_q[IDX_W-1:0];
    end
  end

  // Base address of the taken page: the page number is registered first, then multiplied by the page size.
  logic [IDX_W-1:0]  hit_idx_q;
  logic [BIT_W-1:0]  hit_bit_q;
  logic [P1_W-1:0]   prod1_q;
  logic [MUL_W-1:0]  base_full;
  logic [ADDR_W-1:0] page_q;
  logic              found_q;

  assign base_full = MUL_W'(prod1_q) * MUL_W'(PAGE_BYTES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_take) begin
      hit_idx_q <= rd_idx_q;
      hit_bit_q <= low_idx;
    end
    if (cmd_i.base_mul) begin
      prod1_q <= P1_W'(hit_idx_q) * P1_W'(BITS_PER_WORD) + P1_W'(hit_bit_q);
    end
    if (cmd_i.out_load_hit) begin
      page_q  <= base_full[ADDR_W-1:0];
      found_q <= 1'b1;
    end else if (cmd_i.out_load_miss) begin
      page_q  <= '0;
      found_q <= 1'b0;
    end
  end

  assign page_address_o = page_q;
  assign found_o        = found_q;

  assign sts_o.free_oob = (32'(word_num) >= 32'(MAP_WORDS));
  assign sts_o.ptr_last = (ptr_q == CNT_W'(MAP_WORDS - 1));
  assign sts_o.ptr_end  = (ptr_q == CNT_W'(MAP_WORDS));
  assign sts_o.rd_vld   = rd_vld_q;
  assign sts_o.scan_hit = rd_vld_q && (rdata_q != '0);

endmodule

>>> hdl/bitmap_page_frame_allocator_unit.sv
`timescale 1ns / 1ps
// Allocate: the scan reads map words in order from word zero up to the first nonzero
//   word, at most MAP_WORDS reads through the single read port of the bitmap; the lowest
//   set bit is then taken, and the result waits until the response side is free.
// Free: one word read and one write; a page past the map is dropped without either.
// After reset a clearing pass writes zero to all MAP_WORDS words, one per cycle,
//   and no word is accepted until it ends. One item is in flight at a time.
// ---------------------------------------------------------------------------
// Bitmap page frame allocator, first fit
// Frees pages by byte address and hands out the lowest free page.
// ---------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit import bpfa_pkg::*; #(
  parameter int MAP_WORDS     = 1024,
  parameter int BITS_PER_WORD = 32,
  parameter int PAGE_BYTES    = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpfa_in_if.sink   req_i,
  bpfa_out_if.source rsp_o
);

  bpfa_cmd_t cmd;
  bpfa_sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_mode_i   (req_i.mode),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpfa_datapath #(
    .MAP_WORDS     (MAP_WORDS),
    .BITS_PER_WORD (BITS_PER_WORD),
    .PAGE_BYTES    (PAGE_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_address_i   (req_i.address),
    .sts_o          (sts),
    .page_address_o (rsp_o.page_address),
    .found_o        (rsp_o.found)
  );

endmodule

>>> hdl/bpfa_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator port checker
// Watches the request and response ports of the allocator over time.
// ---------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_unit_macros.svh"

module bpfa_checker import bpfa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ADDR_W-1:0] page_address_i,
  input logic              found_i
);

  // A stalled response word keeps its valid and its payload.
  `BPFAU_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(page_address_i) && $stable(found_i))

  // A failed allocation always reports page zero.
  `BPFAU_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_i && !found_i, page_address_i == '0)

  // Every accepted word keeps the unit busy, so ready is low after the accept.
  `BPFAU_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // The clearing pass holds off requests right after reset.
  `BPFAU_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clk_i, !rst_ni, !in_ready_i)

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker u_bpfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .page_address_i (rsp_o.page_address),
  .found_i        (rsp_o.found)
);
